[hw/rtl/mdu_pkg.sv]
// Shared types, codes and helpers for the multiply/divide unit.
// No dependencies.
`default_nettype none
package mdu_pkg;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_IMUL = 2'd1,
        OP_DIV  = 2'd2,
        OP_IDIV = 2'd3
    } op_t;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Classified request as it waits between front and back.
    typedef struct packed {
        logic        is_div;
        logic        is_signed;
        logic [1:0]  ws;
        logic [32:0] a_ext;   // multiplicand, sign or zero extended
        logic [32:0] b_ext;   // multiplier, sign or zero extended
        logic [63:0] nm;      // dividend magnitude
        logic [31:0] dm;      // divisor magnitude
        logic        nneg;
        logic        qneg;
        logic        err;     // divide fault found up front
    } entry_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FINISH
    } div_state_t;

    function automatic logic [31:0] width_mask(input logic [1:0] ws);
        logic [31:0] m;
        case (ws)
            WIDTH_8:  m = 32'h0000_00ff;
            WIDTH_16: m = 32'h0000_ffff;
            default:  m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] width_bits(input logic [1:0] ws);
        logic [5:0] b;
        case (ws)
            WIDTH_8:  b = 6'd8;
            WIDTH_16: b = 6'd16;
            default:  b = 6'd32;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/mdu_front.sv]
// Front end: masks and extends operands, takes magnitudes, flags divide faults.
// Depends on mdu_pkg.
`default_nettype none
module mdu_front (
    input  wire logic [1:0]     op,
    input  wire logic [1:0]     width_sel,
    input  wire logic [31:0]    acc_low,
    input  wire logic [31:0]    acc_high,
    input  wire logic [31:0]    source_operand,
    output mdu_pkg::entry_t     entry
);

    logic [31:0] mask;
    logic [31:0] a;
    logic [31:0] b;
    logic        sgn;
    logic        a_top;
    logic        b_top;
    logic [63:0] n;
    logic        n_top;
    logic [63:0] nsx;
    logic [63:0] nm;
    logic [63:0] nm_hi;
    logic [32:0] b_ext;
    logic [32:0] b_neg;
    logic [31:0] dm;

    always_comb
    begin
        mask = mdu_pkg::width_mask(width_sel);
        a    = acc_low & mask;
        b    = source_operand & mask;
        sgn  = op[0];
        case (width_sel)
            mdu_pkg::WIDTH_8:
            begin
                a_top = a[7];
                b_top = b[7];
                n     = {48'd0, acc_low[15:0]};
                n_top = n[15];
                nsx   = {{48{sgn & n[15]}}, n[15:0]};
            end
            mdu_pkg::WIDTH_16:
            begin
                a_top = a[15];
                b_top = b[15];
                n     = {32'd0, acc_high[15:0], acc_low[15:0]};
                n_top = n[31];
                nsx   = {{32{sgn & n[31]}}, n[31:0]};
            end
            default:
            begin
                a_top = a[31];
                b_top = b[31];
                n     = {acc_high, acc_low};
                n_top = n[63];
                nsx   = n;
            end
        endcase

        entry.is_div    = op[1];
        entry.is_signed = sgn;
        entry.ws        = width_sel;
        entry.a_ext     = {1'b0, a} | ({33{sgn & a_top}} & ~{1'b0, mask});
        b_ext           = {1'b0, b} | ({33{sgn & b_top}} & ~{1'b0, mask});
        entry.b_ext     = b_ext;

        entry.nneg = sgn & n_top;
        nm         = entry.nneg ? (64'd0 - nsx) : n;
        b_neg      = 33'd0 - b_ext;
        dm         = (sgn & b_top) ? b_neg[31:0] : b;
        entry.qneg = entry.nneg ^ (sgn & b_top);
        entry.nm   = nm;
        entry.dm   = dm;

        case (width_sel)
            mdu_pkg::WIDTH_8:  nm_hi = {8'd0, nm[63:8]};
            mdu_pkg::WIDTH_16: nm_hi = {16'd0, nm[63:16]};
            default:           nm_hi = {32'd0, nm[63:32]};
        endcase
        // quotient needs more than w bits when the upper half already reaches the divisor
        entry.err = op[1] & ((b == 32'd0) | (nm_hi >= {32'd0, dm}));
    end

endmodule
`default_nettype wire

[hw/rtl/mdu_queue.sv]
// Short request queue between the front end and the execution back end.
// Depends on mdu_pkg.
`default_nettype none
module mdu_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mdu_pkg::entry_t push_data,
    input  wire logic            pop,
    output mdu_pkg::entry_t      head,
    output logic                 empty,
    output logic                 full
);

    mdu_pkg::entry_t mem [mdu_pkg::QDEPTH];
    logic [mdu_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mdu_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mdu_pkg::QPTR_W:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (mdu_pkg::QPTR_W+1)'(mdu_pkg::QDEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mdu_back.sv]
// Back end: pipelined multiplier and a one-bit-per-cycle restoring divider,
// with the registered result strobe. Depends on mdu_pkg.
`default_nettype none
module mdu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mdu_pkg::entry_t head,
    input  wire logic            empty,
    output logic                 pop,
    output logic                 done,
    output logic [31:0]          result_low,
    output logic [31:0]          result_high,
    output logic                 carry_overflow,
    output logic                 divide_error
);

    // multiply pipe
    logic              pv_reg;
    logic signed [65:0] p_reg;
    logic [1:0]        p_ws_reg;
    logic              p_sgn_reg;

    // divider
    mdu_pkg::div_state_t state_reg, state_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] nlo_reg, nlo_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] dm_reg, dm_next;
    logic [1:0]  d_ws_reg, d_ws_next;
    logic        d_sgn_reg, d_sgn_next;
    logic        nneg_reg, nneg_next;
    logic        qneg_reg, qneg_next;
    logic        err_reg, err_next;

    logic        pop_div;
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    // output
    logic        done_reg;
    logic [31:0] lo_reg, hi_reg;
    logic        cf_reg, de_reg;

    logic [31:0] m_mask, m_lo, m_hi;
    logic [65:0] m_ext;
    logic        m_cf;
    logic [31:0] d_mask, q_neg, r_neg, lim;
    logic        d_fault;

    assign pop     = !empty && (state_reg == mdu_pkg::DIV_IDLE);
    assign pop_div = pop && head.is_div;

    // restoring step
    always_comb
    begin
        trial = {rem_reg, nlo_reg[31]};
        ge    = (trial >= {1'b0, dm_reg});
        diff  = trial - {1'b0, dm_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        dm_next    = dm_reg;
        d_ws_next  = d_ws_reg;
        d_sgn_next = d_sgn_reg;
        nneg_next  = nneg_reg;
        qneg_next  = qneg_reg;
        err_next   = err_reg;
        case (state_reg)
            mdu_pkg::DIV_IDLE:
            begin
                if (pop_div)
                begin
                    dm_next    = head.dm;
                    d_ws_next  = head.ws;
                    d_sgn_next = head.is_signed;
                    nneg_next  = head.nneg;
                    qneg_next  = head.qneg;
                    err_next   = head.err;
                    q_next     = '0;
                    cnt_next   = mdu_pkg::width_bits(head.ws);
                    case (head.ws)
                        mdu_pkg::WIDTH_8:
                        begin
                            rem_next = {24'd0, head.nm[15:8]};
                            nlo_next = {head.nm[7:0], 24'd0};
                        end
                        mdu_pkg::WIDTH_16:
                        begin
                            rem_next = {16'd0, head.nm[31:16]};
                            nlo_next = {head.nm[15:0], 16'd0};
                        end
                        default:
                        begin
                            rem_next = head.nm[63:32];
                            nlo_next = head.nm[31:0];
                        end
                    endcase
                    state_next = head.err ? mdu_pkg::DIV_FINISH : mdu_pkg::DIV_RUN;
                end
            end
            mdu_pkg::DIV_RUN:
            begin
                rem_next = ge ? diff[31:0] : trial[31:0];
                q_next   = {q_reg[30:0], ge};
                nlo_next = {nlo_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = mdu_pkg::DIV_FINISH;
                end
            end
            mdu_pkg::DIV_FINISH:
            begin
                state_next = mdu_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = mdu_pkg::DIV_IDLE;
            end
        endcase
    end

    // multiply result shaping
    always_comb
    begin
        m_mask = mdu_pkg::width_mask(p_ws_reg);
        m_lo   = p_reg[31:0] & m_mask;
        case (p_ws_reg)
            mdu_pkg::WIDTH_8:
            begin
                m_hi  = {24'd0, p_reg[15:8]};
                m_ext = {{58{p_sgn_reg & p_reg[7]}}, p_reg[7:0]};
            end
            mdu_pkg::WIDTH_16:
            begin
                m_hi  = {16'd0, p_reg[31:16]};
                m_ext = {{50{p_sgn_reg & p_reg[15]}}, p_reg[15:0]};
            end
            default:
            begin
                m_hi  = p_reg[63:32];
                m_ext = {{34{p_sgn_reg & p_reg[31]}}, p_reg[31:0]};
            end
        endcase
        m_cf = (m_ext != p_reg);
    end

    // divide result shaping
    always_comb
    begin
        d_mask  = mdu_pkg::width_mask(d_ws_reg);
        lim     = (d_mask >> 1) + {31'd0, qneg_reg};
        q_neg   = 32'd0 - q_reg;
        r_neg   = 32'd0 - rem_reg;
        d_fault = err_reg | (d_sgn_reg & (q_reg > lim));
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head.is_div)
        begin
            p_reg     <= $signed(head.a_ext) * $signed(head.b_ext);
            p_ws_reg  <= head.ws;
            p_sgn_reg <= head.is_signed;
        end
        rem_reg   <= rem_next;
        nlo_reg   <= nlo_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        dm_reg    <= dm_next;
        d_ws_reg  <= d_ws_next;
        d_sgn_reg <= d_sgn_next;
        nneg_reg  <= nneg_next;
        qneg_reg  <= qneg_next;
        err_reg   <= err_next;
        if (pv_reg)
        begin
            lo_reg <= m_lo;
            hi_reg <= m_hi;
            cf_reg <= m_cf;
            de_reg <= 1'b0;
        end
        else if (state_reg == mdu_pkg::DIV_FINISH)
        begin
            lo_reg <= d_fault ? 32'd0 : ((qneg_reg ? q_neg : q_reg) & d_mask);
            hi_reg <= d_fault ? 32'd0 : ((nneg_reg ? r_neg : rem_reg) & d_mask);
            cf_reg <= 1'b0;
            de_reg <= d_fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdu_pkg::DIV_IDLE;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= pop && !head.is_div;
            done_reg  <= pv_reg || (state_reg == mdu_pkg::DIV_FINISH);
        end
    end

    assign done           = done_reg;
    assign result_low     = lo_reg;
    assign result_high    = hi_reg;
    assign carry_overflow = cf_reg;
    assign divide_error   = de_reg;

endmodule
`default_nettype wire

[hw/rtl/x86_multiply_divide_unit_core.sv]
// x86 MUL/IMUL/DIV/IDIV unit at 8, 16 and 32 bits: top level.
// Depends on mdu_pkg, mdu_front, mdu_queue, mdu_back.
//
// A request is taken when start is high and busy is low; results come back
// in request order, each on the result ports for one cycle with done high,
// and cannot be held off. Multiplies issue one per cycle while the divider
// is idle (one 33x33 multiplier stage). A divide runs the restoring divider
// one quotient bit per cycle (w = 8, 16 or 32 bits), then a finish state,
// or goes straight to finish on a divide fault found up front; while it
// runs, later requests wait in a four-entry queue and busy rises when full.
`default_nettype none
module x86_multiply_divide_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [1:0]  width_sel,
    input  wire logic [31:0] acc_low,
    input  wire logic [31:0] acc_high,
    input  wire logic [31:0] source_operand,
    output logic             done,
    output logic [31:0]      result_low,
    output logic [31:0]      result_high,
    output logic             carry_overflow,
    output logic             divide_error
);

    mdu_pkg::entry_t front_entry;
    mdu_pkg::entry_t head;
    logic            empty;
    logic            full;
    logic            pop;

    mdu_front u_front (
        .op             (op),
        .width_sel      (width_sel),
        .acc_low        (acc_low),
        .acc_high       (acc_high),
        .source_operand (source_operand),
        .entry          (front_entry)
    );

    mdu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !full),
        .push_data (front_entry),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    mdu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .done           (done),
        .result_low     (result_low),
        .result_high    (result_high),
        .carry_overflow (carry_overflow),
        .divide_error   (divide_error)
    );

    assign busy = full;

endmodule
`default_nettype wire

[tb/x86_multiply_divide_unit_core_tb.sv]
// Testbench for x86_multiply_divide_unit_core: MUL/IMUL/DIV/IDIV at 8/16/32 bits.
// Depends on mdu_pkg and the RTL; expected results come from a local predictor.
`timescale 1ns / 100ps
module x86_multiply_divide_unit_core_tb;
    import mdu_pkg::*;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        cf;
        logic        de;
    } mdu_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [1:0]  width_sel;
    logic [31:0] acc_low;
    logic [31:0] acc_high;
    logic [31:0] source_operand;
    logic        done;
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        carry_overflow;
    logic        divide_error;

    mdu_result_t pending_results[$];
    int          error_count;

    x86_multiply_divide_unit_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .width_sel(width_sel), .acc_low(acc_low), .acc_high(acc_high),
        .source_operand(source_operand), .done(done), .result_low(result_low),
        .result_high(result_high), .carry_overflow(carry_overflow),
        .divide_error(divide_error)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] sign_extend(input logic [63:0] v, input int bits);
        logic [63:0] sb;
        logic [63:0] m;
        sb = 64'd1 << (bits - 1);
        m = (bits >= 64) ? '1 : ((64'd1 << bits) - 1);
        return ((v & m) ^ sb) - sb;
    endfunction

    function automatic mdu_result_t mdu_compute(input op_t opc, input logic [1:0] ws,
            input logic [31:0] alo, input logic [31:0] ahi, input logic [31:0] src);
        mdu_result_t r;
        int          w;
        logic [63:0] mask, p, n, d, ns, ds, nm, dm, qm, rm, lim;
        logic        nneg, dneg, qneg;
        r = '{32'd0, 32'd0, 1'b0, 1'b0};
        w = (ws == WIDTH_8) ? 8 : (ws == WIDTH_16) ? 16 : 32;
        mask = (64'd1 << w) - 1;
        case (opc)
            OP_MUL:
            begin
                p = ({32'd0, alo} & mask) * ({32'd0, src} & mask);
                r.lo = 32'(p & mask);
                r.hi = 32'((p >> w) & mask);
                r.cf = ((p >> w) & mask) != 0;
            end
            OP_IMUL:
            begin
                p = sign_extend({32'd0, alo}, w) * sign_extend({32'd0, src}, w);
                r.lo = 32'(p & mask);
                r.hi = 32'((p >> w) & mask);
                r.cf = p != sign_extend(p & mask, w);
            end
            default:
            begin
                d = {32'd0, src} & mask;
                if (w == 8)
                    n = {48'd0, alo[15:0]};
                else if (w == 16)
                    n = {32'd0, ahi[15:0], alo[15:0]};
                else
                    n = {ahi, alo};
                if (d == 0)
                    r.de = 1'b1;
                else if (opc == OP_DIV)
                begin
                    if (n / d > mask)
                        r.de = 1'b1;
                    else
                    begin
                        r.lo = 32'(n / d);
                        r.hi = 32'(n % d);
                    end
                end
                else
                begin
                    ns = sign_extend(n, 2 * w);
                    ds = sign_extend(d, w);
                    nneg = ns[63];
                    dneg = ds[63];
                    nm = nneg ? -ns : ns;
                    dm = dneg ? -ds : ds;
                    qm = nm / dm;
                    rm = nm % dm;
                    qneg = nneg != dneg;
                    lim = (64'd1 << (w - 1)) - (qneg ? 64'd0 : 64'd1);
                    if (qm > lim)
                        r.de = 1'b1;
                    else
                    begin
                        r.lo = 32'((qneg ? -qm : qm) & mask);
                        r.hi = 32'((nneg ? -rm : rm) & mask);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Drive one request and hold it until accepted; random gap afterwards.
    task automatic send_request(input op_t opc, input logic [1:0] ws,
            input logic [31:0] alo, input logic [31:0] ahi, input logic [31:0] src);
        int gap;
        start <= 1'b1;
        op <= opc;
        width_sel <= ws;
        acc_low <= alo;
        acc_high <= ahi;
        source_operand <= src;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(mdu_compute(opc, ws, alo, ahi, src));
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        mdu_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result lo=%h hi=%h", $time, result_low, result_high);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result_low !== e.lo || result_high !== e.hi ||
                    carry_overflow !== e.cf || divide_error !== e.de)
                begin
                    $display("%0t: mismatch expected lo=%h hi=%h cf=%b de=%b", $time,
                             e.lo, e.hi, e.cf, e.de);
                    $display("%0t:          actual   lo=%h hi=%h cf=%b de=%b", $time,
                             result_low, result_high, carry_overflow, divide_error);
                    error_count++;
                end
            end
        end
    end

    task automatic test_multiply_corners();
        logic [1:0] ws;
        for (int i = 0; i < 3; i++)
        begin
            ws = i[1:0];
            send_request(OP_MUL, ws, 32'hffff_ffff, 32'h0, 32'hffff_ffff);
            send_request(OP_IMUL, ws, 32'h8000_0080, 32'h0, 32'h8000_8080);
            send_request(OP_IMUL, ws, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
        end
        // unused width selector behaves as 32 bits
        send_request(OP_MUL, 2'd3, 32'h0001_0000, 32'h0, 32'h0001_0000);
        send_request(OP_IMUL, 2'd3, 32'h7fff_ffff, 32'h0, 32'h0000_0002);
    endtask

    task automatic test_divide_corners();
        send_request(OP_DIV, WIDTH_8, 32'h0000_1234, 32'h0, 32'h0);
        send_request(OP_DIV, WIDTH_8, 32'h0000_ffff, 32'h0, 32'h0000_00ff);
        send_request(OP_DIV, WIDTH_16, 32'h0000_ffff, 32'h0000_fffe, 32'h0000_ffff);
        send_request(OP_DIV, WIDTH_32, 32'hffff_ffff, 32'hffff_fffe, 32'hffff_ffff);
        send_request(OP_DIV, 2'd3, 32'h0, 32'h0000_0001, 32'h0000_0001);
        // signed quotient exactly at the negative limit, and one past the positive
        send_request(OP_IDIV, WIDTH_8, 32'h0000_ff80, 32'h0, 32'h0000_0001);
        send_request(OP_IDIV, WIDTH_8, 32'h0000_0080, 32'h0, 32'h0000_0001);
        send_request(OP_IDIV, WIDTH_16, 32'h0000_0000, 32'h0000_ffff, 32'h0000_0002);
        send_request(OP_IDIV, WIDTH_32, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
        send_request(OP_IDIV, WIDTH_32, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_IDIV, WIDTH_32, 32'hffff_fff9, 32'hffff_ffff, 32'h0000_0002);
        send_request(OP_IDIV, WIDTH_16, 32'h1234_5678, 32'hdead_beef, 32'h0000_0000);
    endtask

    task automatic test_random_requests();
        op_t         opc;
        logic [1:0]  ws;
        logic [31:0] alo, ahi, src;
        int          w;
        for (int i = 0; i < 500; i++)
        begin
            opc = op_t'($urandom_range(0, 3));
            ws = 2'($urandom_range(0, 3));
            w = (ws == WIDTH_8) ? 8 : (ws == WIDTH_16) ? 16 : 32;
            alo = $urandom();
            ahi = $urandom();
            src = $urandom();
            // most divides keep the high dividend small so the quotient fits
            if (opc == OP_DIV && $urandom_range(0, 3) != 0)
            begin
                if (w == 8)
                    alo[15:8] = alo[15:8] % (src[7:0] | 8'd1);
                else if (w == 16)
                    ahi[15:0] = ahi[15:0] % (src[15:0] | 16'd1);
                else
                    ahi = ahi % (src | 32'd1);
            end
            else if (opc == OP_IDIV && $urandom_range(0, 3) != 0)
            begin
                if (w == 8)
                    alo[15:8] = {8{alo[7]}};
                else if (w == 16)
                    ahi[15:0] = {16{alo[15]}};
                else
                    ahi = {32{alo[31]}};
            end
            if ($urandom_range(0, 15) == 0)
                src = 32'h0;
            send_request(opc, ws, alo, ahi, src);
        end
    endtask

    initial
    begin
        int drain;
        error_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_MUL;
        width_sel = WIDTH_8;
        acc_low = '0;
        acc_high = '0;
        source_operand = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_multiply_corners();
        test_divide_corners();
        test_random_requests();
        start <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mdu_pkg.sv
hw/rtl/mdu_front.sv
hw/rtl/mdu_queue.sv
hw/rtl/mdu_back.sv
hw/rtl/x86_multiply_divide_unit_core.sv
tb/x86_multiply_divide_unit_core_tb.sv
